FILE: rtl/sorted_list_insert_remove_core_assert.svh
// Assertion macros shared by the sorted list RTL.
// Included by the core module, which checks its own logic; needs no package.
`ifndef SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_CORE_ASSERT_SVH
`ifndef SYNTH
`define SLIR_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sorted list check failed");
`define SLIR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sorted list check failed");
`else
`define SLIR_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SLIR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/slir_pkg.sv
// Package for the sorted list core: sizes, operation and status codes,
// and the command struct that the top level hands to every cell.
package slir_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } slir_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } slir_status_e;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic                     found;
    logic signed [DATA_W-1:0] value;
  } slir_cmd_t;

endpackage

FILE: rtl/slir_if.sv
// Request and response channel interfaces of the sorted list core.
// Depends on slir_pkg for the field widths.
interface slir_req_if;
  logic                              valid;
  logic                              ready;
  logic [slir_pkg::OP_W-1:0]         opcode;
  logic signed [slir_pkg::DATA_W-1:0] value;
  logic [slir_pkg::POS_W-1:0]        position;

  modport source (output valid, opcode, value, position, input ready);
  modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface slir_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [slir_pkg::STAT_W-1:0]        status;
  logic [slir_pkg::CNT_W-1:0]         count;
  logic signed [slir_pkg::DATA_W-1:0] read_value;

  modport source (output valid, status, count, read_value, input ready);
  modport sink   (input valid, status, count, read_value, output ready);
endinterface

FILE: rtl/sorted_list_insert_remove_core.sv
// Sorted list core: one request gives one registered response in the next cycle.
// Throughput is one request per cycle while the response channel does not stall; the whole cell chain shifts at once.
// A response register sits between the cells and the response channel.
// Reset empties the list and drops the pending response; entry contents
// are not cleared, only the count.
module sorted_list_insert_remove_core (
  input  logic clk_i,
  input  logic rst_ni,
  slir_req_if.sink   req_i,
  slir_rsp_if.source rsp_o
);
  import slir_pkg::*;

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     rsp_valid_q;
  logic [STAT_W-1:0]        rsp_status_q;
  logic [CNT_W-1:0]         rsp_count_q;
  logic signed [DATA_W-1:0] rsp_data_q;

  logic                     accept;
  slir_op_e                 op;
  logic                     full;
  logic                     found;
  logic                     pos_ok;
  slir_status_e             status_d;
  logic signed [DATA_W-1:0] data_d;
  slir_cmd_t                cmd;

  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_gt;
  logic [CAPACITY-1:0]      cell_eq;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign op          = slir_op_e'(req_i.opcode);
  assign full        = (count_q == CNT_W'(CAPACITY));
  assign found       = |cell_eq;
  assign pos_ok      = (CNT_W'(req_i.position) < count_q);

  assign cmd.ins   = accept && (op == OP_INSERT) && !full;
  assign cmd.rem   = accept && (op == OP_REMOVE);
  assign cmd.found = found;
  assign cmd.value = req_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slir_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (CNT_W'(i) < count_q),
      .gt_left_i   ((i == 0) ? 1'b1 : cell_gt[(i == 0) ? 0 : i - 1]),
      .left_val_i  (cell_val[(i == 0) ? 0 : i - 1]),
      .right_val_i (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i]),
      .eq_o        (cell_eq[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    data_d   = '0;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      OP_READ: begin
        if (pos_ok) begin
          data_d = cell_val[req_i.position[IDX_W-1:0]];
        end else begin
          status_d = ST_BAD_POS;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_status_q <= status_d;
      rsp_count_q  <= count_d;
      rsp_data_q   <= data_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.count      = rsp_count_q;
  assign rsp_o.read_value = rsp_data_q;

`include "sorted_list_insert_remove_core_assert.svh"

  `SLIR_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY))
  `SLIR_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, cmd.ins, count_q == $past(count_q) + CNT_W'(1))
  `SLIR_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, accept && (op == OP_CLEAR), count_q == '0)
  `SLIR_ASSERT_SAME(a_full_status, clk_i, rst_ni, rsp_valid_q && (rsp_status_q == ST_FULL), rsp_count_q == CNT_W'(CAPACITY))
  `SLIR_ASSERT_SAME(a_zero_on_fail, clk_i, rst_ni, rsp_valid_q && (rsp_status_q != ST_OK), rsp_data_q == '0)

endmodule

FILE: rtl/slir_cell.sv
// One storage cell of the sorted list chain: holds one entry and takes
// the new value or a neighbor's entry on insert and remove.
// Depends on slir_pkg.
module slir_cell (
  input  logic                               clk_i,
  input  slir_pkg::slir_cmd_t                cmd_i,
  input  logic                               valid_i,
  input  logic                               gt_left_i,
  input  logic signed [slir_pkg::DATA_W-1:0] left_val_i,
  input  logic signed [slir_pkg::DATA_W-1:0] right_val_i,
  output logic signed [slir_pkg::DATA_W-1:0] val_o,
  output logic                               gt_o,
  output logic                               eq_o
);
  import slir_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     ge;

  // gt_o marks cells that stay in front of an inserted value.
  assign gt_o = valid_i && (cmd_i.value > val_q);
  assign eq_o = valid_i && (cmd_i.value == val_q);
  assign ge   = valid_i && !(val_q < cmd_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins && !gt_o) begin
      val_d = gt_left_i ? cmd_i.value : left_val_i;
    end else if (cmd_i.rem && cmd_i.found && ge) begin
      // Entries from the first match onward close the gap.
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: sim/sorted_list_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted list core: watches the request and response channels,
// keeps its own copy of the list and compares every response with it.
// Depends on slir_pkg and the channel interfaces in slir_if.sv.
module sorted_list_checker (
  input  logic clk_i,
  input  logic rst_ni,
  slir_req_if  req_i,
  slir_rsp_if  rsp_i,
  input  logic end_of_test_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o,
  output int   full_rejects_o,
  output int   absent_removes_o,
  output int   bad_reads_o,
  output int   deepest_o
);
  import slir_pkg::*;

  typedef struct {
    slir_status_e               status;
    logic [CNT_W-1:0]           count;
    logic signed [DATA_W-1:0]   read_value;
  } list_rsp_t;

  // Values held by the list, ascending, duplicates allowed.
  logic signed [DATA_W-1:0] held_values[$];
  list_rsp_t                pending_results[$];
  list_rsp_t                predicted;
  list_rsp_t                oldest;
  int                       errors = 0;
  int                       pending = 0;
  int                       checked = 0;
  int                       full_rejects = 0;
  int                       absent_removes = 0;
  int                       bad_reads = 0;
  int                       deepest = 0;
  logic                     leftovers_done = 1'b0;

  assign errors_o         = errors;
  assign pending_o        = pending;
  assign checked_o        = checked;
  assign full_rejects_o   = full_rejects;
  assign absent_removes_o = absent_removes;
  assign bad_reads_o      = bad_reads;
  assign deepest_o        = deepest;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic predict_list_op(input slir_op_e op, input logic signed [DATA_W-1:0] val,
                                 input logic [POS_W-1:0] pos, output list_rsp_t r);
    int at;
    r.status     = ST_OK;
    r.read_value = '0;
    case (op)
      OP_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // A new value lands before any equal entries already held.
          at = 0;
          while (at < held_values.size() && val > held_values[at]) at++;
          held_values.insert(at, val);
        end
      end
      OP_REMOVE: begin
        at = 0;
        while (at < held_values.size() && held_values[at] != val) at++;
        if (at == held_values.size()) begin
          r.status = ST_NOT_FOUND;
        end else begin
          held_values.delete(at);
        end
      end
      OP_CLEAR: begin
        held_values.delete();
      end
      OP_READ: begin
        if (pos < held_values.size()) begin
          r.read_value = held_values[pos];
        end else begin
          r.status = ST_BAD_POS;
        end
      end
    endcase
    r.count = CNT_W'(held_values.size());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        predict_list_op(slir_op_e'(req_i.opcode), req_i.value, req_i.position, predicted);
        pending_results.push_back(predicted);
        if (held_values.size() > deepest) deepest = held_values.size();
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("response with no request waiting (status %0d count %0d)",
                                    rsp_i.status, rsp_i.count));
        end else begin
          oldest = pending_results.pop_front();
          checked++;
          case (oldest.status)
            ST_FULL:      full_rejects++;
            ST_NOT_FOUND: absent_removes++;
            ST_BAD_POS:   bad_reads++;
            default:      ;
          endcase
          if (rsp_i.status !== oldest.status)
            report_mismatch($sformatf("response %0d status got %0d want %0d",
                                      checked, rsp_i.status, oldest.status));
          if (rsp_i.count !== oldest.count)
            report_mismatch($sformatf("response %0d count got %0d want %0d",
                                      checked, rsp_i.count, oldest.count));
          if (rsp_i.read_value !== oldest.read_value)
            report_mismatch($sformatf("response %0d read_value got %0d want %0d",
                                      checked, rsp_i.read_value, oldest.read_value));
        end
      end
      pending = pending_results.size();
      if (end_of_test_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (pending_results.size() != 0)
          report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));
      end
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Top of the sorted list core testbench: clock, reset, request stimulus and
// response pacing. Depends on slir_pkg, slir_if.sv and sorted_list_checker.
module tb;
  import slir_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic end_of_test = 1'b0;
  logic rsp_hold = 1'b0;
  int   send_idle_pct = 30;
  int   rcv_idle_pct = 47;
  int   n_sent = 0;
  int   errors, pending, checked, full_rejects, absent_removes, bad_reads, deepest;

  slir_req_if req ();
  slir_rsp_if rsp ();

  sorted_list_insert_remove_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  sorted_list_checker u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .end_of_test_i    (end_of_test),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked),
    .full_rejects_o   (full_rejects),
    .absent_removes_o (absent_removes),
    .bad_reads_o      (bad_reads),
    .deepest_o        (deepest)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    rsp.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp.ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_req(input slir_op_e op, input logic signed [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.value    <= val;
    req.position <= pos;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    n_sent++;
  endtask

  // Small values on 45 of 100 picks so that duplicates and successful removes are common.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return int'($urandom_range(8)) - 4;
    if (sel < 55) return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom();
  endfunction

  // Requests come in runs of 30 that lean toward filling, draining or a mix.
  task automatic run_random(input int n_items);
    int          lean;
    int unsigned r;
    slir_op_e    op;
    lean = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) lean = $urandom_range(2);
      r = $urandom_range(99);
      case (lean)
        0:       op = (r < 70) ? OP_INSERT : (r < 80) ? OP_REMOVE : (r < 98) ? OP_READ : OP_CLEAR;
        1:       op = (r < 15) ? OP_INSERT : (r < 70) ? OP_REMOVE : (r < 98) ? OP_READ : OP_CLEAR;
        default: op = (r < 35) ? OP_INSERT : (r < 65) ? OP_REMOVE : (r < 95) ? OP_READ : OP_CLEAR;
      endcase
      send_req(op, pick_value(), POS_W'($urandom_range(15)));
    end
  endtask

  initial begin
    int guard;
    req.valid    = 1'b0;
    req.opcode   = OP_INSERT;
    req.value    = '0;
    req.position = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty list first: read, absent remove and clear all act on nothing.
    send_req(OP_READ,   '0, '0);
    send_req(OP_REMOVE, 5, '0);
    send_req(OP_CLEAR,  '0, '0);
    // Fill past capacity with both extremes and zero three times; the last insert is rejected as full.
    send_req(OP_INSERT, 32'sh7fff_ffff, '0);
    send_req(OP_INSERT, 32'sh8000_0000, '0);
    send_req(OP_INSERT, 0, '0);
    send_req(OP_INSERT, -1, '0);
    send_req(OP_INSERT, 1, '0);
    send_req(OP_INSERT, 0, '0);
    for (int k = 0; k < 10; k++) send_req(OP_INSERT, k * 1000 - 5000, '0);
    send_req(OP_INSERT, 7, '0);
    send_req(OP_READ,   '0, 4'd0);
    send_req(OP_READ,   '0, 4'd15);
    send_req(OP_REMOVE, 0, '0);
    send_req(OP_REMOVE, 12345, '0);
    send_req(OP_READ,   '0, 4'd15);
    send_req(OP_CLEAR,  '0, '0);

    run_random(135);

    send_idle_pct = 47;
    rcv_idle_pct  = 30;
    run_random(135);

    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    // The response side stalls for a long stretch while requests keep coming.
    fork
      begin
        @(negedge clk_i);
        rsp_hold <= 1'b1;
        repeat (40) @(negedge clk_i);
        rsp_hold <= 1'b0;
      end
    join_none
    run_random(135);

    @(negedge clk_i);
    req.valid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Sent %0d requests under three pacing mixes, including a 40-cycle response stall.",
             n_sent);
    $display("Checked %0d responses: %0d full rejects, %0d absent removes, %0d bad reads, depth %0d.",
             checked, full_rejects, absent_removes, bad_reads, deepest);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
